### hdl/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int FRAME_W = 10;
    localparam int CNT_W   = 8;
    localparam int FIELD_W = 11;

    // request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // address field width for memory port structs
    localparam int ADDR_MAX_W = 16;

    // count memory access
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        logic [CNT_W-1:0]      wr_data;
    } t_cnt_req;

    // stack memory access
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        logic [FRAME_W-1:0]    wr_data;
    } t_stk_req;

endpackage

### hdl/pfa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface pfa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [pfa_pkg::FRAME_W-1:0] frame_number;

    modport source (output valid, output action, output frame_number, input ready);
    modport sink   (input valid, input action, input frame_number, output ready);
endinterface

interface pfa_rsp_if;
    logic                        valid;
    logic                        ready;
    pfa_pkg::t_status            status;
    logic [pfa_pkg::FRAME_W-1:0] alloc_frame;
    logic                        released;
    logic [pfa_pkg::FIELD_W-1:0] free_frames;

    modport source (output valid, output status, output alloc_frame, output released,
                    output free_frames, input ready);
    modport sink   (input valid, input status, input alloc_frame, input released,
                    input free_frames, output ready);
endinterface

### hdl/pfa_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_stack_mem
// Free frame stack storage, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfa_stack_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                        i_clk,
    input  pfa_pkg::t_stk_req           i_req,
    output logic [pfa_pkg::FRAME_W-1:0] o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [pfa_pkg::FRAME_W-1:0] r_mem [DEPTH];
    logic [pfa_pkg::FRAME_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/pfa_count_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_count_mem
// Per-frame reference counts with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pfa_count_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfa_pkg::t_cnt_req         i_req,
    output logic [pfa_pkg::CNT_W-1:0] o_rd_data,
    output logic                      o_busy
);

    localparam int AW = $clog2(DEPTH);

    logic [pfa_pkg::CNT_W-1:0] r_mem [DEPTH];
    logic [pfa_pkg::CNT_W-1:0] r_rd_data;
    logic [AW-1:0]             r_clr_addr;
    logic                      r_busy;

    // clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // write port, sweep has priority
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

### hdl/page_frame_allocator_refcount.sv
`timescale 1ns / 1ps
// Timing: an accepted item waits in S_EXEC until the output register is free, then its result
// is loaded into that register. No new item is accepted until the state returns to S_IDLE;
// the count and stack memories are read on accept, ahead of the read-modify-write in the
// execute state. Reset: a clearing pass over all NUM_FRAMES entries zeroes the reference
// counts; no item is accepted meanwhile, configuration writes are taken as ever.
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page frame allocator with a LIFO free stack and per-frame reference counts.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
    parameter int NUM_FRAMES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pfa_pkg::FIELD_W-1:0] i_cfg_data,
    pfa_req_if.sink                     i_req,
    pfa_rsp_if.source                   o_rsp
);

    localparam int AW = $clog2(NUM_FRAMES);
    localparam int DW = $clog2(NUM_FRAMES + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                      r_state;
    logic [pfa_pkg::FIELD_W-1:0] r_first_usable;
    logic [DW-1:0]               r_depth;
    logic                        r_action;
    logic [pfa_pkg::FRAME_W-1:0] r_frame;

    logic                        r_out_valid;
    pfa_pkg::t_status            r_out_status;
    logic [pfa_pkg::FRAME_W-1:0] r_out_frame;
    logic                        r_out_released;
    logic [pfa_pkg::FIELD_W-1:0] r_out_free;

    pfa_pkg::t_cnt_req           cnt_req;
    pfa_pkg::t_stk_req           stk_req;
    logic [pfa_pkg::CNT_W-1:0]   cnt_rd_data;
    logic [pfa_pkg::FRAME_W-1:0] stk_rd_data;
    logic                        cnt_busy;

    logic                        accept;
    logic                        fire;
    logic                        frame_ok;
    logic [pfa_pkg::CNT_W-1:0]   cnt_dec;
    logic [DW-1:0]               n_depth;
    pfa_pkg::t_status            n_status;
    logic [pfa_pkg::FRAME_W-1:0] n_frame;
    logic                        n_released;

    pfa_count_mem #(
        .DEPTH (NUM_FRAMES)
    ) u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (cnt_req),
        .o_rd_data (cnt_rd_data),
        .o_busy    (cnt_busy)
    );

    pfa_stack_mem #(
        .DEPTH (NUM_FRAMES)
    ) u_stack (
        .i_clk     (i_clk),
        .i_req     (stk_req),
        .o_rd_data (stk_rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign fire        = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_usable <= '0;
        end else if (i_cfg_we) begin
            r_first_usable <= i_cfg_data;
        end
    end

    // memory reads on accept, decision and write-back in the execute cycle
    always_comb begin
        cnt_req         = '0;
        stk_req         = '0;
        cnt_req.rd_en   = accept;
        cnt_req.rd_addr = pfa_pkg::ADDR_MAX_W'(AW'(i_req.frame_number));
        stk_req.rd_en   = accept && (i_req.action == pfa_pkg::ACT_ALLOC);
        stk_req.rd_addr = pfa_pkg::ADDR_MAX_W'(AW'(r_depth - 1'b1));

        frame_ok = ({1'b0, r_frame} >= r_first_usable) && (int'(r_frame) < NUM_FRAMES);
        cnt_dec  = (cnt_rd_data != '0) ? cnt_rd_data - 1'b1 : '0;

        n_depth    = r_depth;
        n_status   = pfa_pkg::ST_OK;
        n_frame    = '0;
        n_released = 1'b0;

        if (r_action == pfa_pkg::ACT_ALLOC) begin
            if (r_depth == '0) begin
                n_status = pfa_pkg::ST_EMPTY;
            end else begin
                n_depth         = r_depth - 1'b1;
                n_frame         = stk_rd_data;
                cnt_req.wr_en   = fire && (int'(stk_rd_data) < NUM_FRAMES);
                cnt_req.wr_addr = pfa_pkg::ADDR_MAX_W'(AW'(stk_rd_data));
                cnt_req.wr_data = pfa_pkg::CNT_W'(1);
            end
        end else if (!frame_ok) begin
            n_status = pfa_pkg::ST_INVALID;
        end else begin
            cnt_req.wr_en   = fire;
            cnt_req.wr_addr = pfa_pkg::ADDR_MAX_W'(AW'(r_frame));
            cnt_req.wr_data = cnt_dec;
            if (cnt_dec != '0) begin
                n_status = pfa_pkg::ST_OK;
            end else if (int'(r_depth) >= NUM_FRAMES) begin
                n_status = pfa_pkg::ST_FULL;
            end else begin
                stk_req.wr_en   = fire;
                stk_req.wr_addr = pfa_pkg::ADDR_MAX_W'(AW'(r_depth));
                stk_req.wr_data = r_frame;
                n_depth         = r_depth + 1'b1;
                n_released      = 1'b1;
            end
        end
    end

    // control state, stack depth and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (!cnt_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (fire) begin
                r_depth     <= n_depth;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload registers
        if (accept) begin
            r_action <= i_req.action;
            r_frame  <= i_req.frame_number;
        end
        if (fire) begin
            r_out_status   <= n_status;
            r_out_frame    <= n_frame;
            r_out_released <= n_released;
            r_out_free     <= pfa_pkg::FIELD_W'(n_depth);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.alloc_frame = r_out_frame;
    assign o_rsp.released    = r_out_released;
    assign o_rsp.free_frames = r_out_free;

endmodule

### dv/tb_page_frame_allocator_refcount.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_refcount
// Drives allocate and free requests into the page frame allocator and
// predicts every result from its own copy of the free stack, the reference
// counts and the first usable frame. A short directed part covers the empty
// pool, rejected frames, duplicate frees and the register extremes. A full
// boot-time fill takes the stack to its limit, then mixed allocate/free
// traffic runs under several register settings with random stalls.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_refcount;

    localparam int FRAMES      = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENTS    = 5;
    localparam int SEG_ITEMS   = 55;

    typedef struct packed {
        pfa_pkg::t_status              status;
        logic [pfa_pkg::FRAME_W-1:0]   alloc_frame;
        logic                          released;
        logic [pfa_pkg::FIELD_W-1:0]   free_frames;
    } t_frame_result;

    // predicts the allocator and checks its results in order
    class frame_pool_scoreboard;
        logic [pfa_pkg::FRAME_W-1:0] free_stack[FRAMES];
        logic [pfa_pkg::CNT_W-1:0]   ref_count[FRAMES];
        logic [pfa_pkg::FIELD_W-1:0] depth;
        logic [pfa_pkg::FIELD_W-1:0] first_usable;
        t_frame_result               expected_results[$];
        int                          errors;
        int                          n_requests;
        int                          n_released;
        int                          n_status[4];

        function new();
            for (int i = 0; i < FRAMES; i++) begin
                free_stack[i] = '0;
                ref_count[i]  = '0;
            end
            depth        = '0;
            first_usable = '0;
            errors       = 0;
            n_requests   = 0;
            n_released   = 0;
            for (int i = 0; i < 4; i++) n_status[i] = 0;
        endfunction

        function void set_first_usable(logic [pfa_pkg::FIELD_W-1:0] value);
            first_usable = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // note an accepted request and queue the result it must produce
        function t_frame_result predict_request(logic act,
                                                logic [pfa_pkg::FRAME_W-1:0] frame);
            t_frame_result               r;
            logic [pfa_pkg::FRAME_W-1:0] top;
            r.status      = pfa_pkg::ST_OK;
            r.alloc_frame = '0;
            r.released    = 1'b0;
            if (act == pfa_pkg::ACT_ALLOC) begin
                if (depth == 0) begin
                    r.status = pfa_pkg::ST_EMPTY;
                end else begin
                    depth          = depth - 1'b1;
                    top            = free_stack[depth];
                    ref_count[top] = pfa_pkg::CNT_W'(1);
                    r.alloc_frame  = top;
                end
            end else if (int'(frame) < int'(first_usable) || int'(frame) >= FRAMES) begin
                r.status = pfa_pkg::ST_INVALID;
            end else begin
                // a zero count stays zero and still releases the frame
                if (ref_count[frame] != 0) ref_count[frame] = ref_count[frame] - 1'b1;
                if (ref_count[frame] == 0) begin
                    if (int'(depth) >= FRAMES) begin
                        r.status = pfa_pkg::ST_FULL;
                    end else begin
                        free_stack[depth] = frame;
                        depth             = depth + 1'b1;
                        r.released        = 1'b1;
                    end
                end
            end
            r.free_frames = depth;
            expected_results.push_back(r);
            n_requests++;
            n_status[r.status]++;
            if (r.released) n_released++;
            return r;
        endfunction

        // compare one result with the oldest expectation
        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_results.size() == 0) begin
                errors++;
                $error("result with no request pending: status %0d, alloc_frame %0d",
                       got.status, got.alloc_frame);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $error("status: expected %0d, got %0d", want.status, got.status);
            end
            if (got.alloc_frame !== want.alloc_frame) begin
                errors++;
                $error("alloc_frame: expected %0d, got %0d",
                       want.alloc_frame, got.alloc_frame);
            end
            if (got.released !== want.released) begin
                errors++;
                $error("released: expected %0d, got %0d", want.released, got.released);
            end
            if (got.free_frames !== want.free_frames) begin
                errors++;
                $error("free_frames: expected %0d, got %0d",
                       want.free_frames, got.free_frames);
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [pfa_pkg::FIELD_W-1:0] i_cfg_data;

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();

    frame_pool_scoreboard sb;

    // stimulus shaping shared with the result side
    bit calm;
    int hold_requests;
    int n_cfg_writes;

    page_frame_allocator_refcount #(
        .NUM_FRAMES(FRAMES)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: check each accepted item, then pick the next ready value
    int stall_left = 0;
    int hold_left  = 0;
    int holds_seen = 0;

    always @(posedge i_clk) begin : rsp_sink
        t_frame_result got;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.status      = rsp_ch.status;
            got.alloc_frame = rsp_ch.alloc_frame;
            got.released    = rsp_ch.released;
            got.free_frames = rsp_ch.free_frames;
            sb.check_result(got);
        end
        if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            // mostly short stalls, now and then a long one
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(14, 49);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // offer one item after a random gap and wait for it to be taken
    task automatic send_request(input logic act, input logic [pfa_pkg::FRAME_W-1:0] frame,
                                output t_frame_result res);
        int gap;
        int r;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!calm) begin
            if (r >= 90) gap = $urandom_range(8, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.frame_number <= frame;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        res = sb.predict_request(act, frame);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_first_usable(input logic [pfa_pkg::FIELD_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_first_usable(value);
        n_cfg_writes++;
    endtask

    initial begin
        int                          order[FRAMES];
        int                          held[$];
        int                          cfg_plan[SEGMENTS];
        int                          idx;
        int                          j;
        int                          tmp;
        int                          r;
        int                          k;
        logic [pfa_pkg::FRAME_W-1:0] fr;
        t_frame_result               res;

        sb                  = new();
        calm                = 1'b0;
        hold_requests       = 0;
        n_cfg_writes        = 0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_data          = '0;
        req_ch.valid        = 1'b0;
        req_ch.action       = pfa_pkg::ACT_ALLOC;
        req_ch.frame_number = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pool, zero-count frees, duplicates, range checks
        write_first_usable(11'd0);
        send_request(pfa_pkg::ACT_ALLOC, 10'd0, res);
        send_request(pfa_pkg::ACT_FREE, 10'd0, res);
        send_request(pfa_pkg::ACT_FREE, 10'd1023, res);
        send_request(pfa_pkg::ACT_FREE, 10'd1023, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd1023, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd0, res);
        send_request(pfa_pkg::ACT_FREE, 10'd1023, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd512, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd0, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd1023, res);
        write_first_usable(11'd16);
        send_request(pfa_pkg::ACT_FREE, 10'd15, res);
        send_request(pfa_pkg::ACT_FREE, 10'd0, res);
        send_request(pfa_pkg::ACT_FREE, 10'd16, res);
        send_request(pfa_pkg::ACT_FREE, 10'd1023, res);
        write_first_usable(11'd1024);
        send_request(pfa_pkg::ACT_FREE, 10'd1023, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd0, res);
        write_first_usable(11'd2047);
        send_request(pfa_pkg::ACT_FREE, 10'd1023, res);
        send_request(pfa_pkg::ACT_FREE, 10'd0, res);
        write_first_usable(11'd1023);
        send_request(pfa_pkg::ACT_FREE, 10'd1022, res);
        send_request(pfa_pkg::ACT_FREE, 10'd1023, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd1023, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd0, res);
        send_request(pfa_pkg::ACT_ALLOC, 10'd0, res);

        // boot fill: free every frame once in random order until the stack is full
        write_first_usable(11'd0);
        for (int i = 0; i < FRAMES; i++) order[i] = i;
        for (int i = FRAMES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        idx = 0;
        while (int'(sb.depth) < FRAMES) begin
            // long receiver hold while items keep coming back to back
            if (idx == 150) begin
                hold_requests++;
                calm = 1'b1;
            end
            if (idx == 260) calm = 1'b0;
            send_request(pfa_pkg::ACT_FREE, pfa_pkg::FRAME_W'(order[idx % FRAMES]), res);
            idx++;
        end
        calm = 1'b0;

        // pushes onto a full stack, with and without a count to lower
        for (int i = 0; i < 3; i++) begin
            send_request(pfa_pkg::ACT_FREE, pfa_pkg::FRAME_W'($urandom_range(0, 1023)), res);
        end
        send_request(pfa_pkg::ACT_ALLOC, pfa_pkg::FRAME_W'($urandom_range(0, 1023)), res);
        fr = res.alloc_frame;
        send_request(pfa_pkg::ACT_FREE, fr + 10'd1, res);
        send_request(pfa_pkg::ACT_FREE, fr, res);
        send_request(pfa_pkg::ACT_FREE, fr, res);

        // mixed traffic under several register settings
        cfg_plan[0] = $urandom_range(1, 1022);
        cfg_plan[1] = 0;
        cfg_plan[2] = 1024;
        cfg_plan[3] = 2047;
        cfg_plan[4] = $urandom_range(1, 1022);
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_first_usable(pfa_pkg::FIELD_W'(cfg_plan[seg]));
            calm = (seg == 1);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 35 || (r < 70 && held.size() == 0)) begin
                    send_request(pfa_pkg::ACT_ALLOC,
                                 pfa_pkg::FRAME_W'($urandom_range(0, 1023)), res);
                    if (res.status == pfa_pkg::ST_OK) held.push_back(int'(res.alloc_frame));
                end else if (r < 70) begin
                    k  = $urandom_range(0, held.size() - 1);
                    fr = pfa_pkg::FRAME_W'(held[k]);
                    held.delete(k);
                    send_request(pfa_pkg::ACT_FREE, fr, res);
                    if (res.status != pfa_pkg::ST_OK) held.push_back(int'(fr));
                end else if (r < 85) begin
                    send_request(pfa_pkg::ACT_FREE,
                                 pfa_pkg::FRAME_W'($urandom_range(0, 1023)), res);
                end else begin
                    // frames right at the usable boundary
                    fr = pfa_pkg::FRAME_W'(sb.first_usable
                                           - pfa_pkg::FIELD_W'($urandom_range(0, 1)));
                    send_request(pfa_pkg::ACT_FREE, fr, res);
                end
            end
        end
        calm = 1'b0;

        // drain and allow for a late or extra result
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $error("%0d expected results never arrived", sb.pending());
        end

        $display("covered %0d requests: %0d ok, %0d empty pool, %0d invalid frame, %0d full",
                 sb.n_requests, sb.n_status[pfa_pkg::ST_OK], sb.n_status[pfa_pkg::ST_EMPTY],
                 sb.n_status[pfa_pkg::ST_INVALID], sb.n_status[pfa_pkg::ST_FULL]);
        $display("%0d frames released to the pool, %0d first usable frame writes",
                 sb.n_released, n_cfg_writes);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
